// File: hw/rtl/i8rqas_pkg.sv
package i8rqas_pkg;

  localparam int DEF_CHANNELS       = 64;
  localparam int DEF_NUM_INPUTS     = 4;
  localparam int DEF_MULT_FRAC_BITS = 24;

  localparam int SAMPLE_W  = 8;
  localparam int MULT_W    = 32;
  localparam int CHAN_W    = 6;
  localparam int SLOT_W    = 3;
  localparam int USED_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 3;
  localparam int MAX_LANES = 4;

  // sample - zero point, optionally negated
  localparam int DIFF_W = SAMPLE_W + 2;
  localparam int PROD_W = MULT_W + 1 + DIFF_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic MODE_COMPUTE = 1'b0;
  localparam logic MODE_LOAD    = 1'b1;

  localparam logic [SLOT_W-1:0] SLOT_OUT_ZERO = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_OP_SUBTRACT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PER_CHANNEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUTS_USED = 2'd2;

  localparam logic [USED_W-1:0] MIN_USED = 3'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

// File: hw/rtl/int8_requant_elementwise_addsub_core.sv
// Quantized int8 elementwise add/subtract with requantization.
//
// Input channel (in_valid/in_ready): one word per element or table load.
//   mode = load writes one per-channel table entry (multiplier and zero point
//   of an input slot, or the output zero point) and gives no result.
//   mode = compute reads entry rd_addr (channel, or 0) and gives one result word.
// Output channel (out_valid/out_ready): result_value and saturated.
// Config port: cfg_write_en/cfg_index/cfg_data, written while the block idles.
//
// Pipeline: a compute word passes through the registered stages table read,
// multiply, pair sums, final sum and round/saturate to the output. Throughput
// is one word per cycle while out_ready holds; the registered table read and
// the per-lane 33x10 multiplier set the pipeline depth.
// A stalled receiver backs the pipeline up stage by stage; bubbles are
// squeezed out, so in_ready drops only once every stage holds a word.
// Reset clears stage valids and presets the config registers; table contents
// are undefined until loaded, and no load is needed before config writes.
module int8_requant_elementwise_addsub_core #(
  parameter int CHANNELS       = i8rqas_pkg::DEF_CHANNELS,
  parameter int NUM_INPUTS     = i8rqas_pkg::DEF_NUM_INPUTS,
  parameter int MULT_FRAC_BITS = i8rqas_pkg::DEF_MULT_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [i8rqas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i8rqas_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [i8rqas_pkg::CHAN_W-1:0]       channel,
  input  logic signed [i8rqas_pkg::SAMPLE_W-1:0] sample_a,
  input  logic signed [i8rqas_pkg::SAMPLE_W-1:0] sample_b,
  input  logic signed [i8rqas_pkg::SAMPLE_W-1:0] sample_c,
  input  logic signed [i8rqas_pkg::SAMPLE_W-1:0] sample_d,
  input  logic [i8rqas_pkg::SLOT_W-1:0]       load_slot,
  input  logic [i8rqas_pkg::MULT_W-1:0]       load_multiplier,
  input  logic signed [i8rqas_pkg::SAMPLE_W-1:0] load_zero_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [i8rqas_pkg::SAMPLE_W-1:0] result_value,
  output logic                                saturated
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W = i8rqas_pkg::MULT_W + i8rqas_pkg::SAMPLE_W;
  localparam int SW      = i8rqas_pkg::SAMPLE_W;
  localparam int MW      = i8rqas_pkg::MULT_W;
  localparam int DW      = i8rqas_pkg::DIFF_W;
  localparam int AW      = i8rqas_pkg::ACC_W;
  localparam int QW      = AW + 1 - MULT_FRAC_BITS;
  localparam int UW      = i8rqas_pkg::USED_W;
  localparam int NL      = i8rqas_pkg::MAX_LANES;

  // config registers
  logic          op_subtract;
  logic          per_channel;
  logic [UW-1:0] inputs_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_subtract <= 1'b0;
      per_channel <= 1'b1;
      inputs_used <= i8rqas_pkg::MIN_USED;
    end else if (cfg_write_en) begin
      case (cfg_index)
        i8rqas_pkg::CFG_OP_SUBTRACT: op_subtract <= cfg_data[0];
        i8rqas_pkg::CFG_PER_CHANNEL: per_channel <= cfg_data[0];
        i8rqas_pkg::CFG_INPUTS_USED: inputs_used <= cfg_data[UW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids and backpressure
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_accept;

  always_comb begin
    rdy5 = !out_valid || out_ready;
    rdy4 = !s4_valid || rdy5;
    rdy3 = !s3_valid || rdy4;
    rdy2 = !s2_valid || rdy3;
    rdy1 = !s1_valid || rdy2;
  end

  assign in_ready  = rdy1;
  assign in_accept = in_valid && in_ready;

  // channel clamp and table addresses
  logic [31:0]     ch_full;
  logic [CH_W-1:0] ch_idx;
  logic [CH_W-1:0] rd_addr;

  always_comb begin
    ch_full = {{(32 - i8rqas_pkg::CHAN_W){1'b0}}, channel};
    if (ch_full >= 32'(CHANNELS)) begin
      ch_full = 32'(CHANNELS - 1);
    end
    ch_idx  = ch_full[CH_W-1:0];
    rd_addr = per_channel ? ch_idx : '0;
  end

  logic load_accept;
  assign load_accept = in_accept && (mode == i8rqas_pkg::MODE_LOAD);

  // stage 1: table read, samples captured
  i8rqas_pkg::sample_t s1_sample [NL];
  i8rqas_pkg::sample_t in_sample [NL];
  i8rqas_pkg::sample_t rd_ozp;
  logic [MW-1:0]       rd_mult [NL];
  i8rqas_pkg::sample_t rd_zp   [NL];

  assign in_sample[0] = sample_a;
  assign in_sample[1] = sample_b;
  assign in_sample[2] = sample_c;
  assign in_sample[3] = sample_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_accept && (mode == i8rqas_pkg::MODE_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < NL; i++) begin
        s1_sample[i] <= in_sample[i];
      end
    end
  end

  logic [SW-1:0] ozp_mem [CHANNELS];

  always_ff @(posedge clk) begin
    if (load_accept && load_slot == i8rqas_pkg::SLOT_OUT_ZERO) begin
      ozp_mem[ch_idx] <= load_zero_point;
    end
    if (rdy1) begin
      rd_ozp <= ozp_mem[rd_addr];
    end
  end

  // lane enables from inputs_used, clamped to [2, NUM_INPUTS]
  logic [UW-1:0] used_eff;

  always_comb begin
    used_eff = inputs_used;
    if (inputs_used < i8rqas_pkg::MIN_USED) begin
      used_eff = i8rqas_pkg::MIN_USED;
    end else if (inputs_used > UW'(NUM_INPUTS)) begin
      used_eff = UW'(NUM_INPUTS);
    end
  end

  // stage 2: signed difference times multiplier per lane
  i8rqas_pkg::prod_t s2_term [NL];
  i8rqas_pkg::sample_t s2_ozp;

  genvar g;
  for (g = 0; g < NL; g++) begin : gen_lane
    if (g < NUM_INPUTS) begin : gen_used
      logic [ENTRY_W-1:0]  lane_mem [CHANNELS];
      logic                lane_we;
      logic                lane_on;
      logic signed [DW-1:0] diff;
      logic signed [DW-1:0] diff_sgn;
      logic signed [MW:0]   mult_s;
      i8rqas_pkg::prod_t    prod;

      assign lane_we = load_accept && (load_slot == i8rqas_pkg::SLOT_W'(g));

      always_ff @(posedge clk) begin
        if (lane_we) begin
          lane_mem[ch_idx] <= {load_multiplier, load_zero_point};
        end
        if (rdy1) begin
          {rd_mult[g], rd_zp[g]} <= lane_mem[rd_addr];
        end
      end

      always_comb begin
        lane_on  = UW'(g) < used_eff;
        diff     = {{2{s1_sample[g][SW-1]}}, s1_sample[g]}
                 - {{2{rd_zp[g][SW-1]}}, rd_zp[g]};
        diff_sgn = (g != 0 && op_subtract) ? -diff : diff;
        if (!lane_on) begin
          diff_sgn = '0;
        end
        mult_s = {1'b0, rd_mult[g]};
        prod   = mult_s * diff_sgn;
      end

      always_ff @(posedge clk) begin
        if (rdy2) begin
          s2_term[g] <= prod;
        end
      end
    end else begin : gen_idle
      assign rd_mult[g] = '0;
      assign rd_zp[g]   = '0;
      always_ff @(posedge clk) begin
        if (rdy2) begin
          s2_term[g] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_ozp <= rd_ozp;
    end
  end

  // stage 3: pair sums, output zero point scaled
  i8rqas_pkg::acc_t s3_sum01, s3_sum23, s3_oz;
  i8rqas_pkg::acc_t oz_ext;

  assign oz_ext = {{(AW - SW){s2_ozp[SW-1]}}, s2_ozp};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sum01 <= AW'(s2_term[0]) + AW'(s2_term[1]);
      s3_sum23 <= AW'(s2_term[2]) + AW'(s2_term[3]);
      s3_oz    <= oz_ext <<< MULT_FRAC_BITS;
    end
  end

  // stage 4: full sum
  i8rqas_pkg::acc_t s4_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (rdy4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_acc <= s3_sum01 + s3_sum23 + s3_oz;
    end
  end

  // stage 5: round half away from zero, saturate
  logic          acc_neg;
  logic [AW-1:0] mag;
  logic [AW:0]   rnd;
  logic [QW-1:0] q;
  logic          clip;
  logic [SW-1:0] res;

  always_comb begin
    acc_neg = s4_acc[AW-1];
    mag     = acc_neg ? AW'(-s4_acc) : AW'(s4_acc);
    rnd     = {1'b0, mag} + ((AW + 1)'(1) << (MULT_FRAC_BITS - 1));
    q       = rnd[AW:MULT_FRAC_BITS];
    if (acc_neg) begin
      clip = q > QW'(128);
      res  = clip ? 8'h80 : SW'(8'h00 - q[SW-1:0]);
    end else begin
      clip = q > QW'(127);
      res  = clip ? 8'h7f : q[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy5) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      result_value <= res;
      saturated    <= clip;
    end
  end

  // checks
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (result_value == 8'sd127 || result_value == -8'sd128))
    else $error("saturated word not at int8 limit");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == i8rqas_pkg::MODE_LOAD |=> !s1_valid)
    else $error("load word entered compute pipeline");

  a_compute_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == i8rqas_pkg::MODE_COMPUTE |=> s1_valid)
    else $error("compute word lost at pipeline entry");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s2_valid && s3_valid && s4_valid && out_valid && !out_ready))
    else $error("input stalled with a free stage");

endmodule
